@@ rtl/sfd_pkg.sv @@
package sfd_pkg;

  localparam int PAYLOAD_WORDS = 13;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = 5;
  localparam int PHASE_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int WADDR_W     = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

  localparam logic [PHASE_W-1:0] PHASE_HUNT1  = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PHASE_STORE0 = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PHASE_CHECK  = PHASE_W'(2 + 4 * PAYLOAD_WORDS);

  localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(PAYLOAD_WORDS - 1);

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_A = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_B = CFG_INDEX_W'(1);

  localparam logic [BYTE_W-1:0] SYNC_A_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_B_RESET = 8'h55;

  // Payload word write from the front into the back's store.
  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } wr_t;

  // Frame verdict carried through the queue.
  typedef struct packed {
    logic sum_ok;
  } cmd_t;

  // Queue status as seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/sfd_front.sv @@
module sfd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]          in_byte,
  input  sfd_pkg::q_stat_t                    q_stat,
  input  logic                                back_idle,
  output logic                                push,
  output sfd_pkg::cmd_t                       push_cmd,
  output sfd_pkg::wr_t                        wr
);

  logic [sfd_pkg::BYTE_W-1:0]  sync_a;
  logic [sfd_pkg::BYTE_W-1:0]  sync_b;
  logic [sfd_pkg::PHASE_W-1:0] phase;
  logic [sfd_pkg::PHASE_W-1:0] phase_next;
  logic [sfd_pkg::BYTE_W-1:0]  sum;
  logic [sfd_pkg::BYTE_W-1:0]  sum_next;
  logic [23:0]                 lo;
  logic [sfd_pkg::PHASE_W-1:0] offs;
  logic                        fire;
  logic                        hunting;
  logic                        storing;
  logic                        checking;
  logic                        is_sync;

  assign hunting  = (phase < sfd_pkg::PHASE_STORE0);
  assign storing  = !hunting && (phase < sfd_pkg::PHASE_CHECK);
  assign checking = (phase == sfd_pkg::PHASE_CHECK);
  assign is_sync  = (in_byte == sync_a) || (in_byte == sync_b);
  assign offs     = phase - sfd_pkg::PHASE_STORE0;

  // Hold payload bytes while the back still owes words of the last frame.
  always_comb begin
    if (storing) begin
      in_ready = back_idle && q_stat.empty;
    end else if (checking) begin
      in_ready = !q_stat.full;
    end else begin
      in_ready = 1'b1;
    end
  end

  assign fire = in_valid && in_ready;

  always_comb begin
    phase_next = phase;
    sum_next   = sum;
    if (hunting) begin
      if (is_sync) begin
        phase_next = phase + sfd_pkg::PHASE_W'(1);
        if (phase == sfd_pkg::PHASE_HUNT1) begin
          sum_next = '0;
        end
      end
    end else if (storing) begin
      phase_next = phase + sfd_pkg::PHASE_W'(1);
      sum_next   = sum + in_byte;
    end else begin
      phase_next = '0;
      sum_next   = '0;
    end
  end

  assign push            = fire && checking;
  assign push_cmd.sum_ok = (in_byte == sum);

  assign wr.we   = fire && storing && (offs[1:0] == 2'd3);
  assign wr.addr = offs[sfd_pkg::WADDR_W+1:2];
  assign wr.data = {in_byte, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_a <= sfd_pkg::SYNC_A_RESET;
      sync_b <= sfd_pkg::SYNC_B_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::REG_SYNC_A: sync_a <= cfg_data;
        sfd_pkg::REG_SYNC_B: sync_b <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      sum   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      sum   <= sum_next;
    end
  end

  // Assemble little-endian: newest byte enters at the top.
  always_ff @(posedge clk) begin
    if (fire && storing) begin
      lo <= {in_byte, lo[23:8]};
    end
  end

endmodule

@@ rtl/sfd_queue.sv @@
module sfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfd_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output sfd_pkg::cmd_t    head,
  output sfd_pkg::q_stat_t stat
);

  sfd_pkg::cmd_t slot [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;

  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !stat.full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !stat.empty) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push && !stat.full, pop && !stat.empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/sfd_back.sv @@
module sfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sfd_pkg::wr_t                  wr,
  input  sfd_pkg::cmd_t                 head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          idle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfd_pkg::IDX_W-1:0]     word_index,
  output logic [sfd_pkg::WORD_W-1:0]    word_value,
  output logic                          sum_error,
  output logic                          last_of_frame
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [sfd_pkg::WORD_W-1:0] store [sfd_pkg::PAYLOAD_WORDS];
  logic [sfd_pkg::WORD_W-1:0] rd_data;
  logic [1:0]                 state;
  logic [sfd_pkg::IDX_W-1:0]  w;
  logic                       err;
  logic                       at_last;

  assign idle      = (state == ST_IDLE);
  assign pop       = idle && !q_empty;
  assign out_valid = (state == ST_OUT);
  assign at_last   = (w == sfd_pkg::LAST_WORD);

  assign word_index    = err ? '0 : w;
  assign word_value    = err ? '0 : rd_data;
  assign sum_error     = err;
  assign last_of_frame = err || at_last;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      store[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= store[w[sfd_pkg::WADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      w     <= '0;
      err   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            w     <= '0;
            err   <= !head.sum_ok;
            state <= head.sum_ok ? ST_RD : ST_OUT;
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            if (err || at_last) begin
              state <= ST_IDLE;
            end else begin
              w     <= w + sfd_pkg::IDX_W'(1);
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sync_frame_deframer_with_sum_unit.sv @@
// Sync-framed byte deframer with an additive checksum. Bytes enter on the
// slave stream one per request. The front hunts for two header bytes (either
// sync register matches at either position; other bytes are dropped), then
// stores 4*PAYLOAD_WORDS payload bytes as little-endian words and keeps their
// sum modulo 256. The next byte is compared with that sum and the verdict goes
// through a two-entry queue to the back. On a match the back emits
// PAYLOAD_WORDS words, index 0 first, tlast on the final one; on a mismatch it
// emits a single result with tuser set, index 0, value 0 and tlast set.
// The back takes each verdict from the queue; each emitted word then needs
// a store read, then presentation, held while tready is low. An error
// result is presented without a store read. The front keeps taking header
// bytes during the drain but holds payload bytes of the next frame until the
// back is done reading the word store, which is the one memory shared by
// both sides. Configuration writes take effect on the next cycle; index 0 is
// sync_value_a, index 1 is sync_value_b, others are ignored.
module sync_frame_deframer_with_sum_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]        cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // [4:0] word_index,
                                                           // [36:5] word_value, [39:37] zero
  output logic                              m_axis_tuser,  // [0] sum_error
  output logic                              m_axis_tlast   // last_of_frame
);

  sfd_pkg::q_stat_t           q_stat;
  sfd_pkg::cmd_t              push_cmd;
  sfd_pkg::cmd_t              head;
  sfd_pkg::wr_t               wr;
  logic                       push;
  logic                       pop;
  logic                       back_idle;
  logic [sfd_pkg::IDX_W-1:0]  word_index;
  logic [sfd_pkg::WORD_W-1:0] word_value;

  // Hunt, store and check each received byte.
  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .q_stat    (q_stat),
    .back_idle (back_idle),
    .push      (push),
    .push_cmd  (push_cmd),
    .wr        (wr)
  );

  // Frame verdicts wait here for the back; payload bytes still wait for an idle back and empty queue.
  sfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Read the word store and present results.
  sfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .head          (head),
    .q_empty       (q_stat.empty),
    .pop           (pop),
    .idle          (back_idle),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .word_index    (word_index),
    .word_value    (word_value),
    .sum_error     (m_axis_tuser),
    .last_of_frame (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, word_value, word_index};

endmodule
